// File: rtl/core/dpss_pkg.sv
// Shared types and constants of the decaying priority slice scheduler.
package dpss_pkg;

    // Queue depth default
    localparam int MAX_JOBS_DEF = 16;

    // Field widths
    localparam int JOB_W   = 5;
    localparam int TIME_W  = 16;
    localparam int PRI_W   = 16;
    localparam int COUNT_W = 5;
    localparam int TICK_W  = 32;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 88;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SLICE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT = 1'd1;

    // Register reset values
    localparam logic [TIME_W-1:0]  TIME_SLICE_RST    = 16'd1;
    localparam logic [COUNT_W-1:0] PROCESS_COUNT_RST = 5'd1;

    // Input item kinds
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Lowest priority, where decrementing stops
    localparam logic [PRI_W-1:0] PRI_FLOOR = 16'h8000;

    // One queue slot as held in the slot memory
    typedef struct packed {
        logic [JOB_W-1:0]  job_number;
        logic [TIME_W-1:0] exec_time;
        logic [TIME_W-1:0] time_left;
        logic [PRI_W-1:0]  priority_val;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // One result item, last field in the lowest bits
    typedef struct packed {
        logic              pad;
        logic [TICK_W-1:0] tick_number;
        logic              idle;
        logic              completed;
        logic [PRI_W-1:0]  used_priority;
        logic [TIME_W-1:0] time_left;
        logic [TIME_W-1:0] job_exec_time;
        logic [JOB_W-1:0]  job_number;
    } result_t;

endpackage

// File: rtl/core/dpss_ram.sv
// Generic single write port, single read port RAM with registered read data.
module dpss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/decaying_priority_slice_scheduler_top.sv
// Top level of the decaying priority slice scheduler: queue sequencer around one slot RAM.
//
// A load item (tuser 0) appends a job at the tail; loads beyond process_count or a full
// queue are dropped without a result. The slot RAM has one read and one write port and a
// registered read. A tick item (tuser 1) first sweeps the RAM once to find the highest
// priority with a single signed comparator. It then sweeps again from the slot after the
// chosen one to move each later slot down and close the gap. A final state updates the
// job and either writes it back at the tail or retires it. A tick on an empty queue goes
// straight to the final state. The final state of a tick also waits while the previous
// result is still unread. s_tready is high only while no item is in progress; the result
// waits in an output register, so the next item is taken while it is still unread. The
// slot RAM is not cleared; only slots below the queue length are ever read.
module decaying_priority_slice_scheduler_top #(
    parameter int MAX_JOBS = dpss_pkg::MAX_JOBS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dpss_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] exec_time
    input  logic [0:0]                      s_tuser,   // [0] func
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [4:0] job_number, [20:5] job_exec_time, [36:21] time_left, [52:37] used_priority,
    // [53] completed, [54] idle, [86:55] tick_number, [87] zero
    output logic [dpss_pkg::M_TDATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dpss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpss_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int LEN_W = $clog2(MAX_JOBS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    // Control state
    logic [1:0]                     state_reg, state_next;
    logic [LEN_W-1:0]               len_reg, len_next;
    logic [dpss_pkg::COUNT_W-1:0]   jobs_reg, jobs_next;
    logic [dpss_pkg::TICK_W-1:0]    slice_reg, slice_next;
    logic [dpss_pkg::TIME_W-1:0]    ts_reg, ts_next;
    logic [dpss_pkg::COUNT_W-1:0]   pc_reg, pc_next;
    logic [LEN_W-1:0]               rd_ptr_reg, rd_ptr_next;
    logic                           rd_vld_reg, rd_vld_next;
    logic                           idle_tick_reg, idle_tick_next;
    logic                           m_valid_reg, m_valid_next;

    // Payload
    logic [IDX_W-1:0]               rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]               best_idx_reg, best_idx_next;
    dpss_pkg::slot_t                best_reg, best_next;
    dpss_pkg::result_t              out_reg, out_next;

    // Slot RAM port
    logic                           ram_we;
    logic [IDX_W-1:0]               ram_waddr;
    dpss_pkg::slot_t                ram_wdata;
    logic [IDX_W-1:0]               ram_raddr;
    logic [dpss_pkg::SLOT_W-1:0]    ram_rdata;
    dpss_pkg::slot_t                cand;

    // Shared datapath
    logic                           s_acc;
    logic                           out_free;
    logic                           better;
    logic [LEN_W-1:0]               len_dec;
    logic                           done;
    logic [dpss_pkg::TIME_W-1:0]    left_new;
    logic [dpss_pkg::PRI_W-1:0]     pri_dec;

    dpss_ram #(
        .WIDTH (dpss_pkg::SLOT_W),
        .DEPTH (MAX_JOBS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = out_reg;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign cand     = dpss_pkg::slot_t'(ram_rdata);
    assign len_dec  = len_reg - LEN_W'(1);

    // Priority comparator; the first slot always seeds the maximum
    assign better = (rd_idx_reg == '0) ||
                    ($signed(cand.priority_val) > $signed(best_reg.priority_val));

    // Slice arithmetic for the chosen job
    assign done     = (best_reg.time_left <= ts_reg);
    assign left_new = done ? '0 : best_reg.time_left - ts_reg;
    assign pri_dec  = (best_reg.priority_val == dpss_pkg::PRI_FLOOR) ?
                      best_reg.priority_val : best_reg.priority_val - 16'd1;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        jobs_next      = jobs_reg;
        slice_next     = slice_reg;
        ts_next        = ts_reg;
        pc_next        = pc_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        idle_tick_next = idle_tick_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = len_reg[IDX_W-1:0];
        ram_wdata      = '0;
        ram_raddr      = rd_ptr_reg[IDX_W-1:0];

        // Register writes
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                dpss_pkg::CFG_TIME_SLICE:    ts_next = cfg_data;
                dpss_pkg::CFG_PROCESS_COUNT: pc_next = cfg_data[dpss_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser[0] == dpss_pkg::FUNC_LOAD) begin
                        // append a job at the tail unless refused
                        if ((jobs_reg < pc_reg) && (len_reg < LEN_W'(MAX_JOBS))) begin
                            ram_we    = 1'b1;
                            ram_waddr = len_reg[IDX_W-1:0];
                            ram_wdata.job_number   = jobs_reg + 5'd1;
                            ram_wdata.exec_time    = s_tdata;
                            ram_wdata.time_left    = s_tdata;
                            ram_wdata.priority_val = dpss_pkg::PRI_W'(pc_reg) -
                                                     dpss_pkg::PRI_W'(jobs_reg);
                            jobs_next = jobs_reg + 5'd1;
                            len_next  = len_reg + LEN_W'(1);
                        end
                    end else if (len_reg == '0) begin
                        idle_tick_next = 1'b1;
                        state_next     = ST_FIN;
                    end else begin
                        idle_tick_next = 1'b0;
                        rd_ptr_next    = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // issue one read a cycle, compare the slot returned last cycle
                if (rd_ptr_reg < len_reg) begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = rd_ptr_reg[IDX_W-1:0];
                    rd_ptr_next = rd_ptr_reg + LEN_W'(1);
                end
                if (rd_vld_reg && better) begin
                    best_idx_next = rd_idx_reg;
                    best_next     = cand;
                end
                if ((rd_ptr_reg == len_reg) && !rd_vld_reg) begin
                    rd_ptr_next = LEN_W'(best_idx_reg) + LEN_W'(1);
                    state_next  = ST_SHIFT;
                end
            end

            ST_SHIFT: begin
                // move each later slot down by one
                if (rd_ptr_reg < len_reg) begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = rd_ptr_reg[IDX_W-1:0];
                    rd_ptr_next = rd_ptr_reg + LEN_W'(1);
                end
                if (rd_vld_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_reg - IDX_W'(1);
                    ram_wdata = cand;
                end
                if ((rd_ptr_reg == len_reg) && !rd_vld_reg) begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN: begin
                // retire or requeue the job, if any, and present the result
                if (out_free) begin
                    out_next     = '0;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (idle_tick_reg) begin
                        out_next.idle        = 1'b1;
                        out_next.tick_number = slice_reg;
                    end else begin
                        out_next.job_number    = best_reg.job_number;
                        out_next.job_exec_time = best_reg.exec_time;
                        out_next.time_left     = left_new;
                        out_next.used_priority = best_reg.priority_val;
                        out_next.completed     = done;
                        out_next.tick_number   = slice_reg + 32'd1;
                        slice_next             = slice_reg + 32'd1;
                        if (done) begin
                            len_next = len_dec;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = len_dec[IDX_W-1:0];
                            ram_wdata.job_number   = best_reg.job_number;
                            ram_wdata.exec_time    = best_reg.exec_time;
                            ram_wdata.time_left    = left_new;
                            ram_wdata.priority_val = pri_dec;
                        end
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            jobs_reg      <= '0;
            slice_reg     <= '0;
            ts_reg        <= dpss_pkg::TIME_SLICE_RST;
            pc_reg        <= dpss_pkg::PROCESS_COUNT_RST;
            rd_ptr_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            idle_tick_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            jobs_reg      <= jobs_next;
            slice_reg     <= slice_next;
            ts_reg        <= ts_next;
            pc_reg        <= pc_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_vld_reg    <= rd_vld_next;
            idle_tick_reg <= idle_tick_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        out_reg      <= out_next;
    end

endmodule
